@@ hdl/rabs_pkg.sv @@
// Shared constants, beat types and controller/datapath interface structs for rank assignment.
`timescale 1ns / 1ps

package rabs_pkg;

    localparam int MAX_ITEMS     = 64;
    localparam int VALUE_BITS    = 32;   // stored value width, at most IN_VALUE_BITS
    localparam int IN_VALUE_BITS = 32;
    localparam int RANK_BITS     = 6;
    localparam int IDX_W         = $clog2(MAX_ITEMS);
    localparam int CNT_W         = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic signed [IN_VALUE_BITS-1:0] value;
        logic                            is_last;
    } t_in_beat;

    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic                 last_rank;
        logic                 overflow;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic scan_begin;
        logic scan_step;
        logic commit;
        logic emit_begin;
        logic emit_read;
        logic emit_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic idx_end;
        logic pass_end;
        logic rd_pending;
        logic out_free;
    } t_status;

endpackage

@@ hdl/rabs_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rabs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rabs_dpath.sv @@
// Datapath: value and rank stores, ranked flags, minimum search and output register.
`timescale 1ns / 1ps

module rabs_dpath import rabs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_beat  i_in,
    output t_status   o_st,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_beat o_out
);

    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_idx;
    logic [CNT_W-1:0]             r_pass;
    logic                         r_ovf;
    logic                         r_rd_vld;
    logic [IDX_W-1:0]             r_rd_idx;
    logic signed [VALUE_BITS-1:0] r_best_val;
    logic [IDX_W-1:0]             r_best_idx;
    logic                         r_found;
    logic                         r_out_vld;
    t_out_beat                    r_out;

    logic [VALUE_BITS-1:0] w_val_q;
    logic [RANK_BITS-1:0]  w_rank_q;
    logic                  w_flag_q;
    logic                  w_flag_we;
    logic [IDX_W-1:0]      w_flag_waddr;
    logic                  w_full;
    logic                  w_take;
    logic                  w_out_free;

    assign w_full       = (r_count == CNT_W'(MAX_ITEMS));
    assign w_out_free   = !r_out_vld || !i_out_stall;
    // flag is cleared as the entry loads and set when it gets its rank
    assign w_flag_we    = i_cmd.commit || (i_cmd.load && !w_full);
    assign w_flag_waddr = i_cmd.commit ? r_best_idx : r_count[IDX_W-1:0];
    // strict less-than keeps the earlier position on a tie
    assign w_take       = r_rd_vld && !w_flag_q &&
                          (!r_found || ($signed(w_val_q) < r_best_val));

    rabs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && !w_full),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_in.value[VALUE_BITS-1:0]),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_val_q)
    );

    rabs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ITEMS)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (w_flag_we),
        .i_waddr (w_flag_waddr),
        .i_wdata (i_cmd.commit),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_flag_q)
    );

    rabs_ram #(
        .WIDTH (RANK_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_best_idx),
        .i_wdata (RANK_BITS'(r_pass)),
        .i_re    (i_cmd.emit_read),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rank_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_pass    <= '0;
            r_ovf     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.scan_begin || i_cmd.emit_begin) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step || i_cmd.emit_read) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_begin) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_pass <= r_pass + CNT_W'(1);
            end
            if (i_cmd.emit_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_pass  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[IDX_W-1:0];
        if (w_take) begin
            r_best_val <= $signed(w_val_q);
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.emit_load) begin
            r_out.rank      <= w_rank_q;
            r_out.last_rank <= (r_idx == r_count);
            r_out.overflow  <= r_ovf;
        end
    end

    assign o_st.idx_end    = (r_idx == r_count);
    assign o_st.pass_end   = (r_pass == r_count);
    assign o_st.rd_pending = r_rd_vld;
    assign o_st.out_free   = w_out_free;

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

@@ hdl/rabs_ctrl.sv @@
// Controller: sequences load, selection passes and result emission.
`timescale 1ns / 1ps

module rabs_ctrl import rabs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_stall,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS: begin
                if (i_st.pass_end) begin
                    w_cmd.emit_begin = 1'b1;
                    n_state          = S_EMIT_RD;
                end else begin
                    w_cmd.scan_begin = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_st.idx_end) begin
                    w_cmd.scan_step = 1'b1;
                end else if (!i_st.rd_pending) begin
                    w_cmd.commit = 1'b1;
                    n_state      = S_PASS;
                end
            end
            S_EMIT_RD: begin
                w_cmd.emit_read = 1'b1;
                n_state         = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (i_st.out_free) begin
                    w_cmd.emit_load = 1'b1;
                    if (i_st.idx_end) begin
                        w_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != S_LOAD);

endmodule

@@ hdl/rank_assignment_by_selection.sv @@
// Rank assignment by repeated minimum selection over a loaded set of signed values.
// Values are loaded one beat per cycle, up to 64; the beat marked last starts ranking,
// and beats beyond capacity are dropped and flag overflow on every result. Ranking
// runs one selection pass per stored item; each pass scans the value RAM one entry
// a cycle through its single read port. Ranks then leave in load order, each read
// from the rank RAM and then loaded into the output register once it is free, the
// last one marked. Input stays stalled from the last beat until the final result
// sits in the output register, which then waits for the consumer while the next
// set loads.
`timescale 1ns / 1ps

module rank_assignment_by_selection import rabs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    t_cmd    w_cmd;
    t_status w_st;

    rabs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in.is_last),
        .o_in_stall (o_in_stall),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    rabs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in),
        .o_st        (w_st),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

`ifndef SYNTH
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.scan_step, w_cmd.commit, w_cmd.emit_read,
                  w_cmd.emit_load}))
        else $error("datapath commands overlap");

    a_commit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !w_st.pass_end)
        else $error("rank committed beyond stored item count");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_step |-> !w_st.idx_end)
        else $error("scan read past stored items");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_st.rd_pending)
        else $error("input accepted during selection pass");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for rank_assignment_by_selection: random sets, stalls, overflow.
`timescale 1ns / 1ps

module testbench;
    import rabs_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    class rank_checker;
        logic signed [VALUE_BITS-1:0] set_values[$];
        bit                           dropped;
        t_out_beat                    expected_ranks[$];
        int unsigned                  errors;

        function void take_value(t_in_beat beat);
            t_out_beat   res;
            int unsigned r;
            if (set_values.size() < MAX_ITEMS) begin
                set_values.push_back(beat.value[VALUE_BITS-1:0]);
            end else begin
                dropped = 1'b1;
            end
            if (!beat.is_last) return;
            // rank = items that sort ahead; ties go to the earlier load slot
            foreach (set_values[i]) begin
                r = 0;
                foreach (set_values[j]) begin
                    if (set_values[j] < set_values[i] ||
                        (set_values[j] == set_values[i] && j < i)) r++;
                end
                res.rank      = r[RANK_BITS-1:0];
                res.last_rank = (i == set_values.size() - 1);
                res.overflow  = dropped;
                expected_ranks.push_back(res);
            end
            set_values.delete();
            dropped = 1'b0;
        endfunction

        function void check_rank(t_out_beat got);
            t_out_beat want;
            if (expected_ranks.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual rank=%0d last=%0b ovf=%0b",
                         $time, got.rank, got.last_rank, got.overflow);
                errors++;
                return;
            end
            want = expected_ranks.pop_front();
            if (got.rank !== want.rank) begin
                $display("%0t: rank mismatch, expected %0d actual %0d",
                         $time, want.rank, got.rank);
                errors++;
            end
            if (got.last_rank !== want.last_rank) begin
                $display("%0t: last_rank mismatch, expected %0b actual %0b",
                         $time, want.last_rank, got.last_rank);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow mismatch, expected %0b actual %0b",
                         $time, want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in        = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out;

    rank_checker sb = new();

    int unsigned burst_left  = 0;
    int unsigned stall_mode  = 0;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    rank_assignment_by_selection u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // monitor, consumer stall pattern, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.take_value(i_in);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_rank(o_out);

        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end

        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= 1'($urandom_range(0, 1));
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ~i_out_stall;
        endcase
    end

    function automatic logic signed [IN_VALUE_BITS-1:0] rand_value();
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2: return int'($urandom_range(0, 8)) - 4;
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send_beat(input logic signed [IN_VALUE_BITS-1:0] v, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_in.value    <= v;
        i_in.is_last  <= last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin
        int unsigned set_no;
        int unsigned sent;
        int unsigned size;
        int          k;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-item set
        send_beat(0, 1'b1);
        // extremes, duplicates of extremes
        send_beat(32'sh7fff_ffff, 1'b0);
        send_beat(32'sh8000_0000, 1'b0);
        send_beat(0, 1'b0);
        send_beat(-1, 1'b0);
        send_beat(1, 1'b0);
        send_beat(32'sh8000_0000, 1'b0);
        send_beat(32'sh7fff_ffff, 1'b1);
        // all equal
        repeat (4) send_beat(5, 1'b0);
        send_beat(5, 1'b1);
        // strictly descending
        for (k = 3; k >= -2; k--) send_beat(k, k == -2);

        // random sets; one exactly full, one past capacity with the last beat dropped
        set_no = 0;
        sent   = 0;
        while (sent < 150 || set_no < 5) begin
            case (set_no)
                1: size = MAX_ITEMS;
                3: size = MAX_ITEMS + $urandom_range(1, 4);
                default: size = $urandom_range(1, 12);
            endcase
            for (int unsigned n = 0; n < size; n++) send_beat(rand_value(), n == size - 1);
            sent += size;
            set_no++;
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (sb.expected_ranks.size() != 0);
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_ranks.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
